// ===== hdl/tpcb_pkg.sv =====
// Package for the threshold promote cache buffer.
// Holds field widths, register index codes, default parameter values and the
// cell control struct. No dependencies.
package tpcb_pkg;

	// fixed field widths
	localparam int TAG_W     = 64;
	localparam int THR_W     = 16;
	localparam int CAP_W     = 5;
	localparam int HITCNT_W  = 16;
	localparam int OCC_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	// parameter defaults
	localparam int DEF_MAX_ENTRIES = 16;
	localparam int DEF_COUNT_BITS  = 16;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 1'b0,
		REG_CAPACITY  = 1'b1
	} cfg_reg_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;   // latch the key compare result
		logic miss;     // insert at the front, everything moves back
		logic promote;  // matched entry to the front, entries ahead move back
		logic bump;     // matched entry takes the new count in place
	} cell_ctl_t;

endpackage

// ===== hdl/tpcb_cell.sv =====
// One entry of the buffer: tag, hit count and the latched compare result.
// Loads from its front neighbour when the chain moves back. Uses tpcb_pkg.
module tpcb_cell #(
	parameter int COUNT_BITS = tpcb_pkg::DEF_COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tpcb_pkg::cell_ctl_t         ctl,
	input  logic [tpcb_pkg::TAG_W-1:0]  key,
	input  logic                        valid,
	input  logic [COUNT_BITS-1:0]       new_cnt,
	input  logic [tpcb_pkg::TAG_W-1:0]  up_tag,
	input  logic [COUNT_BITS-1:0]       up_cnt,
	input  logic                        below_in,
	output logic                        below_out,
	output logic [tpcb_pkg::TAG_W-1:0]  tag,
	output logic [COUNT_BITS-1:0]       cnt,
	output logic                        match
);
	import tpcb_pkg::*;

	logic [TAG_W-1:0]      tag_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  match_s1;
	logic                  shift;

	// compare stage: only valid entries can match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s1 <= 1'b0;
		end else if (ctl.cmp_en) begin
			match_s1 <= valid && (tag_q == key);
		end
	end

	// move back on a miss, or on a promote if at or ahead of the matched entry
	assign shift = ctl.miss | (ctl.promote & ~below_in);

	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q <= up_tag;
			cnt_q <= up_cnt;
		end else if (ctl.bump && match_s1) begin
			cnt_q <= new_cnt;
		end
	end

	assign below_out = below_in | match_s1;
	assign tag       = tag_q;
	assign cnt       = cnt_q;
	assign match     = match_s1;

endmodule

// ===== hdl/threshold_promote_cache_buffer.sv =====
// Threshold promote cache buffer: an ordered row of MAX_ENTRIES cells, front
// first, each holding a 64-bit tag and a hit count. An item passes the states
// CMP and UPD: in CMP every cell compares the key and latches its match, in
// UPD the row moves back by one place (miss or promote) or the matched cell
// takes its new count, and the result is loaded into the output register.
// A new item is taken in the same cycle as the update, before the last item
// is through, while results are taken; a held result delays the update.
// Configuration must only be written while the block is idle. Uses tpcb_pkg
// and tpcb_cell.
module threshold_promote_cache_buffer #(
	parameter int MAX_ENTRIES = tpcb_pkg::DEF_MAX_ENTRIES,
	parameter int COUNT_BITS  = tpcb_pkg::DEF_COUNT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [tpcb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tpcb_pkg::CFG_W-1:0]     cfg_wdata,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tpcb_pkg::TAG_W-1:0]     key,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic                           promoted,
	output logic                           evicted,
	output logic [tpcb_pkg::TAG_W-1:0]     evicted_key,
	output logic [tpcb_pkg::HITCNT_W-1:0]  hit_count,
	output logic [tpcb_pkg::OCC_W-1:0]     occupancy
);
	import tpcb_pkg::*;

	localparam int NW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	state_t                state_q;
	logic [TAG_W-1:0]      key_q;
	logic [NW-1:0]         n_q;
	logic [THR_W-1:0]      thr_q;
	logic [CAP_W-1:0]      cap_q;
	logic                  out_valid_q;
	logic                  hit_q;
	logic                  promoted_q;
	logic                  evicted_q;
	logic [TAG_W-1:0]      ev_key_q;
	logic [HITCNT_W-1:0]   hit_count_q;
	logic [OCC_W-1:0]      occ_q;

	cell_ctl_t             ctl;
	logic                  upd_go;
	logic                  accept;

	logic [TAG_W-1:0]      tag_a   [MAX_ENTRIES];
	logic [COUNT_BITS-1:0] cnt_a   [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] match_v;
	logic [MAX_ENTRIES-1:0] valid_v;
	logic [MAX_ENTRIES-1:0] last_v;
	logic [MAX_ENTRIES:0]   below_v;

	logic                  any_hit;
	logic [COUNT_BITS-1:0] sel_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [COUNT_BITS-1:0] front_cnt;
	logic                  do_promote;
	logic                  do_evict;
	logic [TAG_W-1:0]      last_tag;
	logic [31:0]           cap_eff;
	logic [NW-1:0]         n_next;
	logic [31:0]           occ32;
	logic [31:0]           cnt32;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1);
			cap_q <= CAP_W'(16);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
				REG_CAPACITY:  cap_q <= cfg_wdata[CAP_W-1:0];
				default:       ;
			endcase
		end
	end

	// handshake
	assign upd_go   = (state_q == ST_UPD) && (!out_valid_q || !out_stall);
	assign in_stall = !((state_q == ST_IDLE) || upd_go);
	assign accept   = in_valid && !in_stall;

	// gather from the cells: at most one valid entry matches
	always_comb begin
		any_hit  = 1'b0;
		sel_cnt  = '0;
		last_tag = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			any_hit  = any_hit | match_v[i];
			sel_cnt  = sel_cnt | (cnt_a[i] & {COUNT_BITS{match_v[i]}});
			last_tag = last_tag | (tag_a[i] & {TAG_W{last_v[i]}});
		end
	end

	// new count, promotion and eviction decisions
	always_comb begin
		new_cnt    = (sel_cnt == {COUNT_BITS{1'b1}}) ? sel_cnt : sel_cnt + COUNT_BITS'(1);
		do_promote = any_hit && !match_v[0] && (32'(new_cnt) > 32'(thr_q));
		front_cnt  = any_hit ? new_cnt : COUNT_BITS'(1);
		cap_eff    = 32'(cap_q);
		if (cap_eff == 32'd0) begin
			cap_eff = 32'd1;
		end
		if (cap_eff > 32'(MAX_ENTRIES)) begin
			cap_eff = 32'(MAX_ENTRIES);
		end
		do_evict = !any_hit && (32'(n_q) >= cap_eff);
		n_next   = (!any_hit && !do_evict) ? n_q + NW'(1) : n_q;
		occ32    = 32'(n_next);
		cnt32    = 32'(front_cnt);
	end

	// control to the cells
	always_comb begin
		ctl.cmp_en  = (state_q == ST_CMP);
		ctl.miss    = upd_go && !any_hit;
		ctl.promote = upd_go && do_promote;
		ctl.bump    = upd_go && any_hit && !do_promote;
	end

	// sequencer, occupancy and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						state_q <= accept ? ST_CMP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (upd_go) begin
				n_q         <= n_next;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// key and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key;
		end
		if (upd_go) begin
			hit_q       <= any_hit;
			promoted_q  <= do_promote;
			evicted_q   <= do_evict;
			ev_key_q    <= do_evict ? last_tag : '0;
			hit_count_q <= cnt32[HITCNT_W-1:0];
			occ_q       <= occ32[OCC_W-1:0];
		end
	end

	// row of cells, front at index 0
	assign below_v[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [TAG_W-1:0]      up_tag;
		logic [COUNT_BITS-1:0] up_cnt;

		assign valid_v[i] = (32'(n_q) > i);
		assign last_v[i]  = (32'(n_q) == i + 1);

		if (i == 0) begin : g_front
			assign up_tag = key_q;
			assign up_cnt = front_cnt;
		end else begin : g_rest
			assign up_tag = tag_a[i-1];
			assign up_cnt = cnt_a[i-1];
		end

		tpcb_cell #(
			.COUNT_BITS(COUNT_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key       (key_q),
			.valid     (valid_v[i]),
			.new_cnt   (new_cnt),
			.up_tag    (up_tag),
			.up_cnt    (up_cnt),
			.below_in  (below_v[i]),
			.below_out (below_v[i+1]),
			.tag       (tag_a[i]),
			.cnt       (cnt_a[i]),
			.match     (match_v[i])
		);
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign promoted    = promoted_q;
	assign evicted     = evicted_q;
	assign evicted_key = ev_key_q;
	assign hit_count   = hit_count_q;
	assign occupancy   = occ_q;

endmodule

// ===== test/tpcb_lookup_checker.sv =====
// Checker for the threshold promote cache buffer: follows the register port,
// predicts one lookup result per input transfer and compares each output transfer.
// Depends on tpcb_pkg only.
module tpcb_lookup_checker
	import tpcb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [TAG_W-1:0]     key,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 hit,
	input  logic                 promoted,
	input  logic                 evicted,
	input  logic [TAG_W-1:0]     evicted_key,
	input  logic [HITCNT_W-1:0]  hit_count,
	input  logic [OCC_W-1:0]     occupancy,
	output int                   pending,
	output int                   fails
);

	localparam int SLOTS       = DEF_MAX_ENTRIES;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic                hit;
		logic                promoted;
		logic                evicted;
		logic [TAG_W-1:0]    evicted_key;
		logic [HITCNT_W-1:0] hit_count;
		logic [OCC_W-1:0]    occupancy;
	} lookup_result_t;

	// shadow copy of the buffer, front at index 0
	logic [TAG_W-1:0]    row_tag [SLOTS];
	logic [HITCNT_W-1:0] row_count [SLOTS];
	int                  row_used;
	logic [THR_W-1:0]    promote_above;
	logic [CAP_W-1:0]    cap_setting;
	lookup_result_t      expected_q [$];
	int                  mismatches;

	// one lookup against the shadow buffer, updating it as the block would
	function automatic lookup_result_t predict_lookup(input logic [TAG_W-1:0] k);
		lookup_result_t      r;
		int                  pos;
		int                  n;
		int                  limit;
		logic [HITCNT_W-1:0] cnt;
		r   = '0;
		pos = -1;
		n   = row_used;
		for (int i = 0; i < n; i++)
			if (pos < 0 && row_tag[i] == k) pos = i;
		if (pos >= 0) begin
			cnt = row_count[pos];
			if (cnt != '1) cnt++;
			row_count[pos] = cnt;
			r.hit = 1'b1;
			// move to the front only from further back
			if (cnt > promote_above && pos != 0) begin
				for (int i = pos; i > 0; i--) begin
					row_tag[i]   = row_tag[i-1];
					row_count[i] = row_count[i-1];
				end
				row_tag[0]   = k;
				row_count[0] = cnt;
				r.promoted   = 1'b1;
			end
		end else begin
			// zero acts as one, anything past the row size as the row size
			limit = (cap_setting == 0) ? 1 :
				(cap_setting > SLOTS) ? SLOTS : int'(cap_setting);
			if (n + 1 > limit) begin
				r.evicted     = 1'b1;
				r.evicted_key = row_tag[n-1];
				n--;
			end
			for (int i = n; i > 0; i--) begin
				row_tag[i]   = row_tag[i-1];
				row_count[i] = row_count[i-1];
			end
			row_tag[0]   = k;
			row_count[0] = HITCNT_W'(1);
			n++;
			cnt = HITCNT_W'(1);
		end
		row_used    = n;
		r.hit_count = cnt;
		r.occupancy = n[OCC_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lookup_result_t got;
		lookup_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				row_tag[i]   = '0;
				row_count[i] = '0;
			end
			row_used      = 0;
			promote_above = THR_W'(1);
			cap_setting   = CAP_W'(16);
			mismatches    = 0;
			expected_q.delete();
			pending <= 0;
			fails   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_THRESHOLD: promote_above = cfg_wdata[THR_W-1:0];
					REG_CAPACITY:  cap_setting   = cfg_wdata[CAP_W-1:0];
					default: ;
				endcase
			end
			// results first: a result never belongs to an input taken at the same edge
			if (out_valid && !out_stall) begin
				got.hit         = hit;
				got.promoted    = promoted;
				got.evicted     = evicted;
				got.evicted_key = evicted_key;
				got.hit_count   = hit_count;
				got.occupancy   = occupancy;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result hit=%0b prom=%0b ev=%0b evkey=%h cnt=%0d occ=%0d",
							got.hit, got.promoted, got.evicted, got.evicted_key,
							got.hit_count, got.occupancy);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("lookup mismatch at %0t", $realtime);
							$display("  expected hit=%0b prom=%0b ev=%0b evkey=%h cnt=%0d occ=%0d",
								want.hit, want.promoted, want.evicted, want.evicted_key,
								want.hit_count, want.occupancy);
							$display("  actual   hit=%0b prom=%0b ev=%0b evkey=%h cnt=%0d occ=%0d",
								got.hit, got.promoted, got.evicted, got.evicted_key,
								got.hit_count, got.occupancy);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_lookup(key));
			pending <= expected_q.size();
			fails   <= mismatches;
		end
	end

endmodule

// ===== test/threshold_promote_cache_buffer_tb.sv =====
// Top of the threshold promote cache buffer testbench: clock, reset, key stimulus,
// register settings, output back-pressure, watchdog and verdict.
// Depends on tpcb_pkg, threshold_promote_cache_buffer and tpcb_lookup_checker.
module threshold_promote_cache_buffer_tb;
	import tpcb_pkg::*;

	localparam int POOL_SIZE      = 24;
	localparam int PHASES         = 11;
	localparam int PHASE_ITEMS    = 100;
	localparam int TAIL_ITEMS     = 150;
	localparam int LONG_HOLD      = 120;
	localparam int CLIMB_HITS     = 40;
	localparam int WATCHDOG_LIMIT = 3000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_THRESHOLD;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [TAG_W-1:0]     key = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 hit;
	logic                 promoted;
	logic                 evicted;
	logic [TAG_W-1:0]     evicted_key;
	logic [HITCNT_W-1:0]  hit_count;
	logic [OCC_W-1:0]     occupancy;
	int                   pending;
	int                   fails;

	logic                 gaps_on = 1'b0;
	logic                 hold_req = 1'b0;
	logic                 hold_served = 1'b0;
	logic [TAG_W-1:0]     key_pool [POOL_SIZE];
	int                   quiet_cycles = 0;

	threshold_promote_cache_buffer u_dut (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_wdata,
		.in_valid, .in_stall, .key,
		.out_valid, .out_stall, .hit, .promoted, .evicted, .evicted_key,
		.hit_count, .occupancy
	);

	tpcb_lookup_checker u_chk (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_wdata,
		.in_valid, .in_stall, .key,
		.out_valid, .out_stall, .hit, .promoted, .evicted, .evicted_key,
		.hit_count, .occupancy, .pending, .fails
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one input transfer, sometimes after a burst of idle cycles
	task automatic send_key(input logic [TAG_W-1:0] k);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key      <= k;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering and wait until every result is back
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// threshold then capacity; spare capacity bits carry noise
	task automatic set_regs(input logic [THR_W-1:0] thr, input logic [CAP_W-1:0] cap);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_idx   <= REG_CAPACITY;
		cfg_wdata <= {(CFG_W-CAP_W)'($urandom), cap};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly keys from a small working set so hits and promotions happen
	function automatic logic [TAG_W-1:0] next_key(input int span);
		if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, span - 1)];
		return {$urandom, $urandom};
	endfunction

	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(0, 6))
			0:       return 0;
			1:       return 1;
			2:       return 2;
			3:       return 3;
			4:       return '1;
			5:       return THR_W'($urandom_range(4, 12));
			default: return THR_W'($urandom);
		endcase
	endfunction

	function automatic logic [CAP_W-1:0] pick_capacity();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 1;
			2:       return 2;
			3:       return 3;
			4:       return 8;
			5:       return 15;
			6:       return 16;
			7:       return 17;
			8:       return '1;
			default: return CAP_W'($urandom);
		endcase
	endfunction

	// output back-pressure: random bursts, plus one long hold on request
	initial begin : back_pressure
		int len;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_served = 1'b1;
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				len = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (len) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: too long without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("threshold_promote_cache_buffer regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int               span;
		logic [TAG_W-1:0] sat_key;
		for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 64'h8000_0000_0000_0001;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: threshold 1, capacity 16
		send_key('0);                    // first access on the empty buffer
		send_key('1);
		send_key('0);                    // first hit, from second place: promoted
		send_key('0);                    // hit at the front: stays put
		send_key('1);
		send_key(64'h8000_0000_0000_0001);
		send_key(64'h5555_5555_5555_5555);

		// capacity dropped below occupancy: each miss drops one, no flush
		drain_block();
		set_regs(0, 2);
		send_key(64'hAAAA_AAAA_AAAA_AAAA);
		send_key('1);
		send_key(64'h5555_5555_5555_5555);

		// zero capacity acts as one
		drain_block();
		set_regs(2, 0);
		send_key(64'h0123_4567_89AB_CDEF);
		send_key(64'h0123_4567_89AB_CDEF);

		// capacity above the row size acts as the row size
		drain_block();
		set_regs('1, '1);
		send_key(64'hFEDC_BA98_7654_3210);
		send_key('0);
		send_key(64'hFEDC_BA98_7654_3210);

		// random phases over a spread of settings
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_block();
			case (ph)
				0:       set_regs(0, 16);
				1:       set_regs('1, 1);
				2:       set_regs(1, '1);
				default: set_regs(pick_threshold(), pick_capacity());
			endcase
			span = $urandom_range(1, POOL_SIZE);
			gaps_on <= (ph % 3 != 2) && (ph != 4);
			if (ph == 4) hold_req <= 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 6 && i == PHASE_ITEMS / 2) drain_block();
				send_key(next_key(span));
			end
		end

		// count climbing under the top threshold never promotes, then one hit
		// over a lowered threshold moves it up from second place
		drain_block();
		set_regs('1, 16);
		gaps_on <= 1'b0;
		sat_key = {$urandom, $urandom};
		send_key(sat_key);
		send_key(~sat_key);
		repeat (CLIMB_HITS) send_key(sat_key);
		drain_block();
		set_regs(THR_W'(CLIMB_HITS), 16);
		send_key(sat_key);

		// closing stretch with no idling on either side
		drain_block();
		set_regs(pick_threshold(), pick_capacity());
		span = $urandom_range(4, POOL_SIZE);
		for (int i = 0; i < TAIL_ITEMS; i++) send_key(next_key(span));

		drain_block();
		repeat (8) @(posedge clk);
		if (fails == 0) begin
			$display("threshold_promote_cache_buffer regression: pass");
		end else begin
			$display("threshold_promote_cache_buffer regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tpcb_pkg.sv
hdl/tpcb_cell.sv
hdl/threshold_promote_cache_buffer.sv
test/tpcb_lookup_checker.sv
test/threshold_promote_cache_buffer_tb.sv
